>>> hw/rtl/rrfc_pkg.sv
package rrfc_pkg;

  // Longest legal frame, in bytes, and the width of the byte position counter.
  localparam int MAX_FRAME = 32;
  localparam int POS_W     = $clog2(MAX_FRAME);

  // Frame layout constants.
  localparam logic [7:0] HEADER_BYTE     = 8'h01;
  localparam logic [7:0] CMD_ECHO_DEFAULT = 8'hA1;
  localparam logic [7:0] MIN_FRAME       = 8'd6;
  localparam logic [7:0] PAYLOAD_START   = 8'd5;
  localparam logic [4:0] PAYLOAD_LIMIT   = 5'd16;
  localparam logic [4:0] PAYLOAD_DEFAULT = 5'd6;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COMMAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_COUNT    = 2'd1;

  // Verdict codes.
  localparam logic [2:0] VERDICT_OK         = 3'd0;
  localparam logic [2:0] VERDICT_CHECKSUM   = 3'd1;
  localparam logic [2:0] VERDICT_STATUS     = 3'd2;
  localparam logic [2:0] VERDICT_MISMATCH   = 3'd3;
  localparam logic [2:0] VERDICT_BAD_LENGTH = 3'd4;

  // Per-frame parser state.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [7:0]       frame_length;
    logic [7:0]       running_xor;
    logic [7:0]       card_status;
    logic             header_command_ok;
  } state_t;

  // Configuration register contents.
  typedef struct packed {
    logic [7:0] expected_command;
    logic [4:0] payload_count;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic       is_verdict;
    logic [7:0] data_byte;
    logic [3:0] payload_index;
    logic [2:0] verdict;
  } result_t;

endpackage

>>> hw/rtl/rrfc_in_if.sv
interface rrfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/rrfc_out_if.sv
interface rrfc_out_if;
  logic       valid;
  logic       ready;
  logic       is_verdict;
  logic [7:0] data_byte;
  logic [3:0] payload_index;
  logic [2:0] verdict;

  modport source (output valid, output is_verdict, output data_byte,
                  output payload_index, output verdict, input ready);
  modport sink (input valid, input is_verdict, input data_byte,
                input payload_index, input verdict, output ready);
endinterface

>>> hw/rtl/rrfc_cfg_if.sv
interface rrfc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rrfc_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/rrfc_step.sv
module rrfc_step (
  input  rrfc_pkg::state_t  state,
  input  rrfc_pkg::cfg_t    cfg,
  input  logic [7:0]        rx_byte,
  output rrfc_pkg::state_t  state_next,
  output logic              has_result,
  output rrfc_pkg::result_t result
);
  import rrfc_pkg::*;

  logic [4:0] payload_used;
  logic [7:0] pos8;
  logic       last_byte;
  logic       restart;

  // Clamp the payload count and widen the position for byte-wide compares.
  assign payload_used = (cfg.payload_count > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT
                                                            : cfg.payload_count;
  assign pos8      = 8'(state.pos);
  assign last_byte = (pos8 + 8'd1) == state.frame_length;

  // One frame byte: update the parser state and form at most one result.
  always_comb begin
    state_next = state;
    has_result = 1'b0;
    result     = '0;
    restart    = 1'b0;

    if (pos8 == 8'd0) begin
      state_next.header_command_ok = (rx_byte == HEADER_BYTE);
    end else if (pos8 == 8'd1) begin
      if (rx_byte < MIN_FRAME || rx_byte > 8'(MAX_FRAME)) begin
        restart           = 1'b1;
        has_result        = 1'b1;
        result.is_verdict = 1'b1;
        result.verdict    = VERDICT_BAD_LENGTH;
      end else begin
        state_next.frame_length = rx_byte;
      end
    end else if (last_byte) begin
      restart           = 1'b1;
      has_result        = 1'b1;
      result.is_verdict = 1'b1;
      if (state.frame_length < MIN_FRAME + 8'(payload_used)) begin
        result.verdict = VERDICT_BAD_LENGTH;
      end else if (rx_byte != ~state.running_xor) begin
        result.verdict = VERDICT_CHECKSUM;
      end else if (state.card_status != 8'd0) begin
        result.verdict = VERDICT_STATUS;
      end else if (!state.header_command_ok) begin
        result.verdict = VERDICT_MISMATCH;
      end else begin
        result.verdict = VERDICT_OK;
      end
    end else if (pos8 == 8'd2) begin
      if (rx_byte != cfg.expected_command) begin
        state_next.header_command_ok = 1'b0;
      end
    end else if (pos8 == 8'd4) begin
      state_next.card_status = rx_byte;
    end

    if (restart) begin
      state_next = '0;
    end else begin
      state_next.running_xor = state.running_xor ^ rx_byte;
      state_next.pos         = state.pos + POS_W'(1);
      // Payload bytes are passed out as they arrive.
      if (pos8 >= PAYLOAD_START && pos8 < PAYLOAD_START + 8'(payload_used)) begin
        has_result           = 1'b1;
        result.data_byte     = rx_byte;
        result.payload_index = 4'(pos8 - PAYLOAD_START);
      end
    end
  end

endmodule

>>> hw/rtl/rrfc_out_buf.sv
module rrfc_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rrfc_pkg::result_t push_data,
  output logic              space,
  rrfc_out_if.source        rsp
);
  import rrfc_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    pop;

  assign pop   = main_valid && rsp.ready;
  assign space = !skid_valid;

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end else begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  assign rsp.valid         = main_valid;
  assign rsp.is_verdict    = main_data.is_verdict;
  assign rsp.data_byte     = main_data.data_byte;
  assign rsp.payload_index = main_data.payload_index;
  assign rsp.verdict       = main_data.verdict;

endmodule

>>> hw/rtl/reader_response_frame_checker_core.sv
// Reader response frame checker. Takes one received byte per beat on rx and
// returns payload bytes and one end-of-frame verdict per frame on rsp. Every
// byte is handled in the cycle it is accepted, so the block takes one byte
// per clock while rx.ready is high; each result is registered in the output
// buffer before it appears on rsp. A two-entry output buffer (output register
// plus skid entry) lets input continue while a result waits; rx.ready drops
// only when both entries are full. Configuration writes on cfg are always
// taken and should be made while no frame is in progress.
module reader_response_frame_checker_core (
  input  logic       clk,
  input  logic       rst,
  rrfc_in_if.sink    rx,
  rrfc_out_if.source rsp,
  rrfc_cfg_if.sink   cfg
);
  import rrfc_pkg::*;

  state_t  state;
  state_t  state_next;
  cfg_t    regs;
  logic    has_result;
  result_t result;
  logic    space;
  logic    rx_fire;

  assign rx.ready  = space;
  assign rx_fire   = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.expected_command <= CMD_ECHO_DEFAULT;
      regs.payload_count    <= PAYLOAD_DEFAULT;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_EXPECTED_COMMAND: regs.expected_command <= cfg.data;
        CFG_PAYLOAD_COUNT:    regs.payload_count    <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  // Parser state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (rx_fire) begin
      state <= state_next;
    end
  end

  rrfc_step u_step (
    .state      (state),
    .cfg        (regs),
    .rx_byte    (rx.rx_byte),
    .state_next (state_next),
    .has_result (has_result),
    .result     (result)
  );

  rrfc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (rx_fire && has_result),
    .push_data (result),
    .space     (space),
    .rsp       (rsp)
  );

  // A verdict always sends the parser back to the frame header.
  a_verdict_restarts: assert property (@(posedge clk) disable iff (rst)
    rx_fire && has_result && result.is_verdict |=> state.pos == '0)
    else $error("parser did not restart after a verdict");

  // Input is held off only while a result is waiting at the output.
  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> rsp.valid)
    else $error("input stalled with empty output");

  // The byte position never reaches the maximum frame length.
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(state.pos) < MAX_FRAME)
    else $error("byte position out of range");

endmodule

>>> tb/reader_response_frame_checker_core_tb.sv
module reader_response_frame_checker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrfc_pkg::*;

  localparam logic [7:0] CMD_ECHO_ALT = 8'hA3;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_BYTES   = 100;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 80;
  localparam int STALL_LIMIT   = 2000;

  typedef enum logic [1:0] {
    FRAME_WELL_FORMED,
    FRAME_BAD_LENGTH,
    FRAME_NOISE
  } frame_kind_t;

  // Tracks the frame parser state and holds the results it predicts.
  class frame_scoreboard;
    logic [7:0]       exp_cmd;
    logic [4:0]       pay_cnt;
    logic [POS_W-1:0] pos;
    logic [7:0]       flen;
    logic [7:0]       rxor;
    logic [7:0]       status;
    logic             hdr_ok;
    result_t          expected_q[$];
    int               errors;
    int               payload_seen;
    int               verdict_seen[5];

    function new();
      errors = 0;
      payload_seen = 0;
      foreach (verdict_seen[i]) verdict_seen[i] = 0;
      exp_cmd = CMD_ECHO_DEFAULT;
      pay_cnt = PAYLOAD_DEFAULT;
      restart();
    endfunction

    function void restart();
      pos = '0;
      flen = '0;
      rxor = '0;
      status = '0;
      hdr_ok = 1'b0;
    endfunction

    // Payload counts above the limit behave as the limit.
    function logic [4:0] payload_used();
      return (pay_cnt > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : pay_cnt;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      if (idx == CFG_EXPECTED_COMMAND) begin
        exp_cmd = data;
      end else if (idx == CFG_PAYLOAD_COUNT) begin
        pay_cnt = data[4:0];
      end
    endfunction

    // Advances the parser by one accepted byte and queues any result it causes.
    function void note_byte(logic [7:0] b);
      result_t          r;
      logic [POS_W-1:0] at;
      logic [4:0]       used;
      at = pos;
      used = payload_used();
      r = '0;
      r.is_verdict = 1'b1;
      if (at == 0) begin
        hdr_ok = (b == HEADER_BYTE);
      end else if (at == 1) begin
        if (b < MIN_FRAME || b > MAX_FRAME) begin
          restart();
          r.verdict = VERDICT_BAD_LENGTH;
          expected_q.push_back(r);
          return;
        end
        flen = b;
      end else if (8'(at) + 8'd1 == flen) begin
        // Last byte of the frame: checks are ranked, length first.
        if (flen < MIN_FRAME + 8'(used)) begin
          r.verdict = VERDICT_BAD_LENGTH;
        end else if (b != ~rxor) begin
          r.verdict = VERDICT_CHECKSUM;
        end else if (status != 8'h00) begin
          r.verdict = VERDICT_STATUS;
        end else if (!hdr_ok) begin
          r.verdict = VERDICT_MISMATCH;
        end else begin
          r.verdict = VERDICT_OK;
        end
        restart();
        expected_q.push_back(r);
        return;
      end else if (at == 2) begin
        if (b != exp_cmd) hdr_ok = 1'b0;
      end else if (at == 4) begin
        status = b;
      end
      rxor = rxor ^ b;
      pos = at + 1'b1;
      if (at >= PAYLOAD_START && at < PAYLOAD_START + 8'(used)) begin
        r.is_verdict = 1'b0;
        r.data_byte = b;
        r.payload_index = 4'(at - PAYLOAD_START);
        expected_q.push_back(r);
      end
    endfunction

    // Compares one result beat with the oldest expectation.
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected result: is_verdict=%0d data=%02h index=%0d verdict=%0d",
                   got.is_verdict, got.data_byte, got.payload_index, got.verdict);
        end
        return;
      end
      want = expected_q.pop_front();
      if (want.is_verdict) begin
        verdict_seen[want.verdict]++;
      end else begin
        payload_seen++;
      end
      if (got.is_verdict !== want.is_verdict || got.data_byte !== want.data_byte ||
          got.payload_index !== want.payload_index || got.verdict !== want.verdict) begin
        errors++;
        if (errors <= 10) begin
          $display("Mismatch: expected is_verdict=%0d data=%02h index=%0d verdict=%0d",
                   want.is_verdict, want.data_byte, want.payload_index, want.verdict);
          $display("          actual   is_verdict=%0d data=%02h index=%0d verdict=%0d",
                   got.is_verdict, got.data_byte, got.payload_index, got.verdict);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   idle_on = 1'b0;
  bit   hold_req = 1'b0;
  int   sent = 0;
  int   idle_cycles = 0;

  frame_scoreboard sb;

  rrfc_in_if  rx_if();
  rrfc_out_if rsp_if();
  rrfc_cfg_if cfg_if();

  reader_response_frame_checker_core dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always #5 clk = ~clk;

  // Offers one byte and waits for its beat; sometimes idles afterwards.
  task automatic send_byte(input logic [7:0] b);
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    sb.note_byte(b);
    sent++;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Finishes whatever frame is open so the next one starts at byte zero.
  task automatic sync_frame();
    while (sb.pos != 0) begin
      send_byte(sb.pos == 1 ? 8'h00 : 8'($urandom));
    end
  endtask

  // Stops input, waits for every pending result, then lets the pipeline settle.
  task automatic drain();
    rx_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers in back-to-back beats.
  task automatic set_config(input logic [7:0] cmd, input logic [4:0] cnt);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_EXPECTED_COMMAND;
    cfg_if.data <= cmd;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(CFG_EXPECTED_COMMAND, cmd);
    cfg_if.index <= CFG_PAYLOAD_COUNT;
    cfg_if.data <= {3'b000, cnt};
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(CFG_PAYLOAD_COUNT, {3'b000, cnt});
    cfg_if.valid <= 1'b0;
  endtask

  // Builds a frame of the given length with a checksum, optionally corrupted.
  task automatic send_built(input logic [7:0] hdr, input logic [7:0] len,
                            input logic [7:0] cmd, input logic [7:0] status,
                            input logic [7:0] fill, input bit rand_fill,
                            input bit bad_sum);
    logic [7:0] fr[$];
    logic [7:0] sum;
    fr.push_back(hdr);
    fr.push_back(len);
    fr.push_back(cmd);
    fr.push_back(rand_fill ? 8'($urandom) : fill);
    fr.push_back(status);
    while (fr.size() < int'(len) - 1) fr.push_back(rand_fill ? 8'($urandom) : fill);
    sum = 8'h00;
    foreach (fr[i]) sum = sum ^ fr[i];
    sum = ~sum;
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    fr.push_back(sum);
    foreach (fr[i]) send_byte(fr[i]);
  endtask

  // Mostly well-formed frames with random faults, some bad lengths and noise.
  task automatic send_random_frame();
    frame_kind_t kind;
    int          pick;
    int          used;
    int          top;
    logic [7:0]  len;
    logic [7:0]  hdr;
    logic [7:0]  cmd;
    logic [7:0]  status;
    pick = $urandom_range(0, 9);
    kind = (pick < 8) ? FRAME_WELL_FORMED : ((pick == 8) ? FRAME_BAD_LENGTH : FRAME_NOISE);
    used = int'(sb.payload_used());
    sync_frame();
    case (kind)
      FRAME_NOISE: begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
      end
      FRAME_BAD_LENGTH: begin
        send_byte($urandom_range(0, 1) ? HEADER_BYTE : 8'($urandom));
        send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, int'(MIN_FRAME) - 1))
                                       : 8'($urandom_range(MAX_FRAME + 1, 255)));
      end
      default: begin
        if (used > 0 && $urandom_range(0, 9) == 0) begin
          len = 8'($urandom_range(int'(MIN_FRAME), int'(MIN_FRAME) + used - 1));
        end else begin
          top = (int'(MIN_FRAME) + used + 4 < MAX_FRAME && $urandom_range(0, 1) == 1)
                ? int'(MIN_FRAME) + used + 4 : MAX_FRAME;
          len = 8'($urandom_range(int'(MIN_FRAME) + used, top));
        end
        hdr = ($urandom_range(0, 9) == 0) ? HEADER_BYTE ^ 8'($urandom_range(1, 255))
                                          : HEADER_BYTE;
        cmd = ($urandom_range(0, 9) == 0) ? sb.exp_cmd ^ 8'($urandom_range(1, 255))
                                          : sb.exp_cmd;
        status = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        send_built(hdr, len, cmd, status, 8'h00, 1'b1, $urandom_range(0, 5) == 0);
      end
    endcase
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      if (hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Checks each result beat and ends the run if no beat moves for too long.
  always @(posedge clk) begin
    result_t got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got.is_verdict = rsp_if.is_verdict;
      got.data_byte = rsp_if.data_byte;
      got.payload_index = rsp_if.payload_index;
      got.verdict = rsp_if.verdict;
      sb.check_result(got);
    end
    if (rst || (rx_if.valid && rx_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                 idle_cycles, sb.expected_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Stimulus: directed frames on reset settings, then random phases.
  initial begin
    logic [7:0] cmd;
    logic [4:0] cnt;
    sb = new();
    rst <= 1'b1;
    rx_if.valid <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_EXPECTED_COMMAND;
    cfg_if.data <= 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // Length byte just below the minimum and just above the maximum.
    send_byte(HEADER_BYTE);
    send_byte(MIN_FRAME - 8'd1);
    send_byte(8'hFF);
    send_byte(8'(MAX_FRAME + 1));
    // Frame too short for the default payload, with zero fill and status bytes.
    send_built(HEADER_BYTE, MIN_FRAME, CMD_ECHO_DEFAULT, 8'h00, 8'h00, 1'b0, 1'b0);
    // Clean frame carrying all-ones payload bytes.
    send_built(HEADER_BYTE, 8'd12, CMD_ECHO_DEFAULT, 8'h00, 8'hFF, 1'b0, 1'b0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin cmd = CMD_ECHO_ALT;     cnt = PAYLOAD_LIMIT; end
        1:       begin cmd = 8'h00;            cnt = 5'd0;          end
        2:       begin cmd = 8'hFF;            cnt = 5'd31;         end
        3:       begin cmd = CMD_ECHO_DEFAULT; cnt = 5'd17;         end
        4:       begin cmd = CMD_ECHO_DEFAULT; cnt = 5'd1;          end
        5:       begin cmd = CMD_ECHO_ALT;     cnt = 5'd15;         end
        default: begin
          cmd = 8'($urandom);
          cnt = 5'($urandom_range(0, 31));
        end
      endcase
      sync_frame();
      drain();
      set_config(cmd, cnt);
      idle_on = (ph % 3 != 2) && (ph != NUM_PHASES - 1);
      // Long result hold-off while full-payload frames keep coming.
      if (ph == 0) hold_req = 1'b1;
      for (int goal = sent + PHASE_BYTES; sent < goal; ) send_random_frame();
    end

    sync_frame();
    drain();
    if (sb.expected_q.size() != 0) begin
      sb.errors += sb.expected_q.size();
      $display("%0d expected results never arrived", sb.expected_q.size());
    end
    $display("Covered %0d bytes over %0d register settings: %0d payload bytes checked",
             sent, NUM_PHASES + 1, sb.payload_seen);
    $display("Verdicts ok/checksum/status/mismatch/length: %0d/%0d/%0d/%0d/%0d",
             sb.verdict_seen[0], sb.verdict_seen[1], sb.verdict_seen[2],
             sb.verdict_seen[3], sb.verdict_seen[4]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
